[rtl/krp_pkg.sv]
// Package for the keyed resource pool: field widths, command and register codes,
// the sequencer state type and the result record. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package krp_pkg;

    localparam int CMD_W       = 2;
    localparam int DIM_W       = 16;
    localparam int CODE_W      = 8;
    localparam int BYTES_W     = 32;
    localparam int HANDLE_W    = 16;
    localparam int KEY_W       = 48;
    localparam int COUNT_W     = 7;
    localparam int STAT_W      = 32;
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 7;

    // Command codes; the remaining code is a no-op.
    localparam logic [CMD_W-1:0] CMD_ACQUIRE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd2;

    // Key kinds.
    localparam logic KIND_TEXTURE = 1'b0;
    localparam logic KIND_BUFFER  = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_TEXTURES = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_BUFFERS  = 4'd1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT,
        ST_FINISH
    } krp_state_t;

    typedef struct packed {
        logic                hit;
        logic [HANDLE_W-1:0] handle_out;
        logic                dropped;
        logic [COUNT_W-1:0]  pooled_textures;
        logic [COUNT_W-1:0]  pooled_buffers;
        logic [STAT_W-1:0]   hit_count;
        logic [STAT_W-1:0]   miss_count;
    } krp_rsp_t;

endpackage

`default_nettype wire

[rtl/krp_if.sv]
// Channel interfaces of the keyed resource pool: request, result and register write.
// Depends on krp_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface krp_req_if import krp_pkg::*; ;
    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   cmd;
    logic               kind;
    logic [DIM_W-1:0]   tex_width;
    logic [DIM_W-1:0]   tex_height;
    logic [CODE_W-1:0]  pixel_format;
    logic [CODE_W-1:0]  usage_bits;
    logic [BYTES_W-1:0] buffer_bytes;
    logic               host_visible;
    logic [HANDLE_W-1:0] handle_in;

    modport source (
        output valid, cmd, kind, tex_width, tex_height, pixel_format, usage_bits,
               buffer_bytes, host_visible, handle_in,
        input  ready
    );
    modport sink (
        input  valid, cmd, kind, tex_width, tex_height, pixel_format, usage_bits,
               buffer_bytes, host_visible, handle_in,
        output ready
    );
endinterface

interface krp_rsp_if import krp_pkg::*; ;
    logic                valid;
    logic                ready;
    logic                hit;
    logic [HANDLE_W-1:0] handle_out;
    logic                dropped;
    logic [COUNT_W-1:0]  pooled_textures;
    logic [COUNT_W-1:0]  pooled_buffers;
    logic [STAT_W-1:0]   hit_count;
    logic [STAT_W-1:0]   miss_count;

    modport source (
        output valid, hit, handle_out, dropped, pooled_textures, pooled_buffers,
               hit_count, miss_count,
        input  ready
    );
    modport sink (
        input  valid, hit, handle_out, dropped, pooled_textures, pooled_buffers,
               hit_count, miss_count,
        output ready
    );
endinterface

interface krp_cfg_if import krp_pkg::*; ;
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

[rtl/krp_mem.sv]
// Entry store of the keyed resource pool: one write port, one read port with
// registered read data. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module krp_mem #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 65
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

[rtl/krp_match.sv]
// Key compare unit of the keyed resource pool: one stored entry against the request key.
// Depends on krp_pkg for the key width.
`timescale 1ns / 1ps
`default_nettype none

module krp_match import krp_pkg::*; (
    input  wire logic             req_kind,
    input  wire logic [KEY_W-1:0] req_key,
    input  wire logic             entry_kind,
    input  wire logic [KEY_W-1:0] entry_key,
    output logic                  match
);

    assign match = (req_kind == entry_kind) && (req_key == entry_key);

endmodule

`default_nettype wire

[rtl/keyed_resource_pool.sv]
// Keyed resource pool top level: sequencer, counters, entry store and compare unit.
// Release, clear and no-op go from accept straight to the finish step; an acquire first
// scans the stack from the top down and, on a hit at entry s, shifts the entries above s
// down one place, all through the single read port of the entry store.
// One request at a time. Reset empties the pool, zeroes counters and limits; no sweep.
`timescale 1ns / 1ps
`default_nettype none

module keyed_resource_pool import krp_pkg::*; #(
    parameter int TABLE_DEPTH = 64,
    parameter int HANDLE_BITS = 16
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    krp_req_if.sink     req,
    krp_rsp_if.source   rsp,
    krp_cfg_if.sink     cfg
);

    // Address width, fill count width, and a compare width with one spare bit
    // so that pointer plus two never wraps.
    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int TW = $clog2(TABLE_DEPTH + 1);
    localparam int CW = TW + 1;
    // Stored handle width: the handle port never carries more than HANDLE_W bits.
    localparam int HW = (HANDLE_BITS < HANDLE_W) ? HANDLE_BITS : HANDLE_W;
    localparam int MW = 1 + KEY_W + HW;

    // Sequencer and request registers.
    krp_state_t          state_reg, state_next;
    logic [CMD_W-1:0]    cmd_reg;
    logic                kind_reg;
    logic [KEY_W-1:0]    key_reg;
    logic [HW-1:0]       handle_reg;
    logic [AW-1:0]       ptr_reg, ptr_next;
    logic                hit_reg, hit_next;
    logic [HW-1:0]       hout_reg, hout_next;

    // Pool status and limits.
    logic [COUNT_W-1:0]  tex_cnt_reg, tex_cnt_next;
    logic [COUNT_W-1:0]  buf_cnt_reg, buf_cnt_next;
    logic [TW-1:0]       total_reg, total_next;
    logic [STAT_W-1:0]   hits_reg, hits_next;
    logic [STAT_W-1:0]   misses_reg, misses_next;
    logic [COUNT_W-1:0]  max_tex_reg;
    logic [COUNT_W-1:0]  max_buf_reg;

    // Result register.
    logic                out_valid_reg, out_valid_next;
    krp_rsp_t            out_reg, out_next;

    // Entry store ports.
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    logic [MW-1:0]       wr_data;
    logic                rd_en;
    logic [AW-1:0]       rd_addr;
    logic [MW-1:0]       rd_data;

    logic                entry_kind;
    logic [KEY_W-1:0]    entry_key;
    logic [HW-1:0]       entry_handle;
    logic                match;

    logic                accept;
    logic                out_free;
    logic [KEY_W-1:0]    req_key;

    assign req.ready = (state_reg == ST_IDLE);
    assign accept    = req.valid && req.ready;
    assign out_free  = !out_valid_reg || rsp.ready;

    // A texture key packs width, height, format and usage; a buffer key packs
    // the byte size and the visibility flag above it.
    always_comb
    begin
        if (req.kind == KIND_TEXTURE)
        begin
            req_key = {req.usage_bits, req.pixel_format, req.tex_height, req.tex_width};
        end
        else
        begin
            req_key = {(KEY_W - BYTES_W - 1)'(0), req.host_visible, req.buffer_bytes};
        end
    end

    assign {entry_kind, entry_key, entry_handle} = rd_data;

    krp_mem #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH (MW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    krp_match u_match (
        .req_kind   (kind_reg),
        .req_key    (key_reg),
        .entry_kind (entry_kind),
        .entry_key  (entry_key),
        .match      (match)
    );

    // Configuration writes are always taken.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_tex_reg <= '0;
            max_buf_reg <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_MAX_TEXTURES: max_tex_reg <= cfg.data;
                REG_MAX_BUFFERS:  max_buf_reg <= cfg.data;
                default:          ;
            endcase
        end
    end

    // The request payload is captured on accept and needs no reset.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg    <= req.cmd;
            kind_reg   <= req.kind;
            key_reg    <= req_key;
            handle_reg <= req.handle_in[HW-1:0];
        end
        ptr_reg  <= ptr_next;
        hout_reg <= hout_next;
        out_reg  <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            hit_reg       <= 1'b0;
            tex_cnt_reg   <= '0;
            buf_cnt_reg   <= '0;
            total_reg     <= '0;
            hits_reg      <= '0;
            misses_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            hit_reg       <= hit_next;
            tex_cnt_reg   <= tex_cnt_next;
            buf_cnt_reg   <= buf_cnt_next;
            total_reg     <= total_next;
            hits_reg      <= hits_next;
            misses_reg    <= misses_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // The entries 0 .. total-1 form a stack in release order. An acquire reads
    // them from the top down, one per cycle, through the compare unit; the read of
    // the next lower entry is issued while the current one is compared. On a hit
    // at entry s, every entry above s is copied one place down, one per cycle, by
    // reading entry j+1 and writing the returned word to entry j. All counts are
    // settled in the finish step, when the result register is free.
    always_comb
    begin
        state_next     = state_reg;
        ptr_next       = ptr_reg;
        hit_next       = hit_reg;
        hout_next      = hout_reg;
        tex_cnt_next   = tex_cnt_reg;
        buf_cnt_next   = buf_cnt_reg;
        total_next     = total_reg;
        hits_next      = hits_reg;
        misses_next    = misses_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_next       = out_reg;
        wr_en          = 1'b0;
        wr_addr        = ptr_reg;
        wr_data        = rd_data;
        rd_en          = 1'b0;
        rd_addr        = ptr_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    hit_next  = 1'b0;
                    hout_next = '0;
                    if (req.cmd == CMD_ACQUIRE && total_reg != '0)
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = AW'(total_reg - TW'(1));
                        ptr_next   = AW'(total_reg - TW'(1));
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end

            ST_SCAN:
            begin
                if (match)
                begin
                    hit_next  = 1'b1;
                    hout_next = entry_handle;
                    if (CW'(ptr_reg) + CW'(1) < CW'(total_reg))
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = ptr_reg + AW'(1);
                        state_next = ST_SHIFT;
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
                else if (ptr_reg == '0)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    rd_en    = 1'b1;
                    rd_addr  = ptr_reg - AW'(1);
                    ptr_next = ptr_reg - AW'(1);
                end
            end

            ST_SHIFT:
            begin
                // rd_data holds entry ptr+1; it moves down to ptr.
                wr_en   = 1'b1;
                wr_addr = ptr_reg;
                wr_data = rd_data;
                if (CW'(ptr_reg) + CW'(2) < CW'(total_reg))
                begin
                    rd_en    = 1'b1;
                    rd_addr  = AW'(CW'(ptr_reg) + CW'(2));
                    ptr_next = ptr_reg + AW'(1);
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end

            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_next.hit        = 1'b0;
                    out_next.handle_out = '0;
                    out_next.dropped    = 1'b0;
                    case (cmd_reg)
                        CMD_ACQUIRE:
                        begin
                            if (hit_reg)
                            begin
                                hits_next  = hits_reg + STAT_W'(1);
                                total_next = total_reg - TW'(1);
                                if (kind_reg == KIND_TEXTURE)
                                begin
                                    tex_cnt_next = tex_cnt_reg - COUNT_W'(1);
                                end
                                else
                                begin
                                    buf_cnt_next = buf_cnt_reg - COUNT_W'(1);
                                end
                                out_next.hit        = 1'b1;
                                out_next.handle_out = HANDLE_W'(hout_reg);
                            end
                            else
                            begin
                                misses_next = misses_reg + STAT_W'(1);
                            end
                        end

                        CMD_RELEASE:
                        begin
                            // A null handle changes nothing and is not a drop.
                            if (handle_reg != '0)
                            begin
                                if ((kind_reg == KIND_TEXTURE && tex_cnt_reg >= max_tex_reg)
                                    || (kind_reg == KIND_BUFFER && buf_cnt_reg >= max_buf_reg)
                                    || CW'(total_reg) >= CW'(TABLE_DEPTH))
                                begin
                                    out_next.dropped = 1'b1;
                                end
                                else
                                begin
                                    wr_en      = 1'b1;
                                    wr_addr    = AW'(total_reg);
                                    wr_data    = {kind_reg, key_reg, handle_reg};
                                    total_next = total_reg + TW'(1);
                                    if (kind_reg == KIND_TEXTURE)
                                    begin
                                        tex_cnt_next = tex_cnt_reg + COUNT_W'(1);
                                    end
                                    else
                                    begin
                                        buf_cnt_next = buf_cnt_reg + COUNT_W'(1);
                                    end
                                end
                            end
                        end

                        CMD_CLEAR:
                        begin
                            // Dropping the fill count empties the stack; the
                            // hit and miss counters are kept.
                            tex_cnt_next = '0;
                            buf_cnt_next = '0;
                            total_next   = '0;
                        end

                        default:
                        begin
                        end
                    endcase
                    out_next.pooled_textures = tex_cnt_next;
                    out_next.pooled_buffers  = buf_cnt_next;
                    out_next.hit_count       = hits_next;
                    out_next.miss_count      = misses_next;
                    out_valid_next           = 1'b1;
                    state_next               = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign rsp.valid           = out_valid_reg;
    assign rsp.hit             = out_reg.hit;
    assign rsp.handle_out      = out_reg.handle_out;
    assign rsp.dropped         = out_reg.dropped;
    assign rsp.pooled_textures = out_reg.pooled_textures;
    assign rsp.pooled_buffers  = out_reg.pooled_buffers;
    assign rsp.hit_count       = out_reg.hit_count;
    assign rsp.miss_count      = out_reg.miss_count;

    // The fill count must always equal the sum of the two per-kind counts.
    a_total_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        32'(total_reg) == 32'(tex_cnt_reg) + 32'(buf_cnt_reg))
        else $error("pool fill count differs from the per-kind counts");

    // The stack never grows past the table.
    a_total_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        32'(total_reg) <= 32'(TABLE_DEPTH))
        else $error("pool fill count exceeds the table depth");

    // Only non-null handles are ever stored, so a hit returns a non-null handle
    // and never reports a drop.
    a_hit_handle: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.hit |-> rsp.handle_out != '0 && !rsp.dropped)
        else $error("hit beat with a null handle or a drop");

    // A new result is only loaded from the finish step.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_FINISH)
        else $error("result loaded outside the finish step");

endmodule

`default_nettype wire

[tb/keyed_resource_pool_test.sv]
// Self-checking testbench for keyed_resource_pool: directed and random acquire, release and
// clear traffic, checked beat by beat against a predictor kept inside this file.
// Depends on krp_pkg, the krp_*_if channel interfaces and the keyed_resource_pool RTL.
`timescale 1ns / 1ps

module keyed_resource_pool_test import krp_pkg::*; ;

    // The DUT is built at its default sizes and the predictor mirrors them.
    localparam int POOL_DEPTH = 64;

    // The one command code that the package leaves unnamed; the block treats it as a no-op.
    localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;

    // Slowest acquire: a hit at the bottom of a full table, which scans and then shifts every entry.
    localparam int DRAIN_CYCLES = 2 * POOL_DEPTH + 10;

    // One request beat, in the same field order as the request channel.
    typedef struct packed {
        logic [CMD_W-1:0]    cmd;
        logic                kind;
        logic [DIM_W-1:0]    tex_width;
        logic [DIM_W-1:0]    tex_height;
        logic [CODE_W-1:0]   pixel_format;
        logic [CODE_W-1:0]   usage_bits;
        logic [BYTES_W-1:0]  buffer_bytes;
        logic                host_visible;
        logic [HANDLE_W-1:0] handle_in;
    } pool_req_t;

    logic clk;
    logic rst_n;

    krp_req_if req_if ();
    krp_rsp_if rsp_if ();
    krp_cfg_if cfg_if ();

    keyed_resource_pool #(
        .TABLE_DEPTH(POOL_DEPTH),
        .HANDLE_BITS(HANDLE_W)
    ) dut (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req_if),
        .rsp  (rsp_if),
        .cfg  (cfg_if)
    );

    // Shadow copy of the pool. Only entries below the live total are ever read, so the
    // entries above it may hold stale data without harm, exactly as in the block.
    logic                pool_kind   [POOL_DEPTH];
    logic [KEY_W-1:0]    pool_key    [POOL_DEPTH];
    logic [HANDLE_W-1:0] pool_handle [POOL_DEPTH];
    int                  pooled_tex;
    int                  pooled_buf;
    logic [STAT_W-1:0]   hit_total;
    logic [STAT_W-1:0]   miss_total;
    int                  tex_limit;
    int                  buf_limit;

    // Results that the predictor has worked out and the result channel still owes us.
    krp_rsp_t expected_results[$];

    int errors;
    int items_sent;
    int results_seen;
    int drops_predicted;
    int full_table_events;

    // Traffic shaping shared between the sender, the receiver and the tests.
    bit steady_flow;
    int result_hold_cycles;

    // Recently used keys, so that random acquires find something to hit.
    pool_req_t key_slots[8];

    // ------------------------------------------------------------------------------------
    // Clock, and a watchdog that ends a run that has hung.
    // ------------------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    initial
    begin : watchdog
        #10_000_000;
        $display("watchdog expired with %0d results still outstanding", expected_results.size());
        $display("status: fail");
        $finish;
    end

    // ------------------------------------------------------------------------------------
    // Predictor.
    // ------------------------------------------------------------------------------------

    // The 48-bit key under which an entry is filed. A buffer key only uses the low 33 bits.
    function automatic logic [KEY_W-1:0] key_of(input pool_req_t r);
        if (r.kind == KIND_TEXTURE)
        begin
            return {r.usage_bits, r.pixel_format, r.tex_height, r.tex_width};
        end
        return {15'd0, r.host_visible, r.buffer_bytes};
    endfunction

    // Applies one accepted request to the shadow pool and returns the result beat it causes.
    function automatic krp_rsp_t predict_pool_step(input pool_req_t r);
        krp_rsp_t         res;
        logic [KEY_W-1:0] key;
        int               total;
        int               found;
        bit               at_limit;
        res   = '0;
        key   = key_of(r);
        total = pooled_tex + pooled_buf;
        case (r.cmd)
            CMD_ACQUIRE:
            begin
                // Scan from the top of the stack so the newest matching handle wins.
                found = -1;
                for (int s = total - 1; s >= 0 && found < 0; s--)
                begin
                    if (pool_kind[s] == r.kind && pool_key[s] == key)
                    begin
                        found = s;
                    end
                end
                if (found >= 0)
                begin
                    res.hit        = 1'b1;
                    res.handle_out = pool_handle[found];
                    // Close the gap so the stack stays compacted in release order.
                    for (int j = found; j + 1 < total; j++)
                    begin
                        pool_kind[j]   = pool_kind[j + 1];
                        pool_key[j]    = pool_key[j + 1];
                        pool_handle[j] = pool_handle[j + 1];
                    end
                    if (r.kind == KIND_TEXTURE)
                    begin
                        pooled_tex--;
                    end
                    else
                    begin
                        pooled_buf--;
                    end
                    hit_total++;
                end
                else
                begin
                    miss_total++;
                end
            end
            CMD_RELEASE:
            begin
                // A null handle is ignored outright and is not reported as dropped.
                if (r.handle_in != '0)
                begin
                    at_limit = (r.kind == KIND_TEXTURE) ? (pooled_tex >= tex_limit)
                                                        : (pooled_buf >= buf_limit);
                    if (at_limit || total >= POOL_DEPTH)
                    begin
                        res.dropped = 1'b1;
                        drops_predicted++;
                    end
                    else
                    begin
                        pool_kind[total]   = r.kind;
                        pool_key[total]    = key;
                        pool_handle[total] = r.handle_in;
                        if (r.kind == KIND_TEXTURE)
                        begin
                            pooled_tex++;
                        end
                        else
                        begin
                            pooled_buf++;
                        end
                        if (total + 1 == POOL_DEPTH)
                        begin
                            full_table_events++;
                        end
                    end
                end
            end
            CMD_CLEAR:
            begin
                // Clear empties the pool but keeps the hit and miss counters.
                pooled_tex = 0;
                pooled_buf = 0;
            end
            default:
            begin
            end
        endcase
        res.pooled_textures = pooled_tex[COUNT_W-1:0];
        res.pooled_buffers  = pooled_buf[COUNT_W-1:0];
        res.hit_count       = hit_total;
        res.miss_count      = miss_total;
        return res;
    endfunction

    // ------------------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------------------

    // Idle length for either side: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
        begin
            return 0;
        end
        if (roll < 90)
        begin
            return $urandom_range(1, 3);
        end
        if (roll < 98)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic int next_gap();
        return steady_flow ? 0 : pick_gap();
    endfunction

    // Texture request; the buffer fields are outside the key and carry random bits.
    function automatic pool_req_t tex_item(input logic [CMD_W-1:0] cmd,
                                           input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                                           input logic [CODE_W-1:0] fmt,
                                           input logic [CODE_W-1:0] usage,
                                           input logic [HANDLE_W-1:0] handle);
        pool_req_t r;
        r              = '0;
        r.cmd          = cmd;
        r.kind         = KIND_TEXTURE;
        r.tex_width    = w;
        r.tex_height   = h;
        r.pixel_format = fmt;
        r.usage_bits   = usage;
        r.buffer_bytes = BYTES_W'($urandom);
        r.host_visible = 1'($urandom_range(0, 1));
        r.handle_in    = handle;
        return r;
    endfunction

    // Buffer request; the texture fields are outside the key and carry random bits.
    function automatic pool_req_t buf_item(input logic [CMD_W-1:0] cmd,
                                           input logic [BYTES_W-1:0] bytes, input logic hv,
                                           input logic [HANDLE_W-1:0] handle);
        pool_req_t r;
        r              = '0;
        r.cmd          = cmd;
        r.kind         = KIND_BUFFER;
        r.tex_width    = DIM_W'($urandom);
        r.tex_height   = DIM_W'($urandom);
        r.pixel_format = CODE_W'($urandom);
        r.usage_bits   = CODE_W'($urandom);
        r.buffer_bytes = bytes;
        r.host_visible = hv;
        r.handle_in    = handle;
        return r;
    endfunction

    function automatic void refresh_key_slot(input int idx);
        key_slots[idx].kind         = 1'($urandom_range(0, 1));
        key_slots[idx].tex_width    = DIM_W'($urandom);
        key_slots[idx].tex_height   = DIM_W'($urandom);
        key_slots[idx].pixel_format = CODE_W'($urandom);
        key_slots[idx].usage_bits   = CODE_W'($urandom);
        key_slots[idx].buffer_bytes = BYTES_W'($urandom);
        key_slots[idx].host_visible = 1'($urandom_range(0, 1));
    endfunction

    // A random request. Most keys come from a small working set so acquires hit; a few are
    // fresh keys and a few differ from a pooled key in one bit, to probe the exact compare.
    function automatic pool_req_t random_item(input int release_pct);
        pool_req_t r;
        int        idx;
        int        key_roll;
        int        cmd_roll;
        idx      = $urandom_range(0, 7);
        key_roll = $urandom_range(0, 99);
        if (key_roll < 12)
        begin
            refresh_key_slot(idx);
        end
        if (key_roll >= 12 && key_roll < 20)
        begin
            r = key_slots[idx];
            if (r.kind == KIND_TEXTURE)
            begin
                case ($urandom_range(0, 3))
                    0: r.tex_width    ^= 16'd1 << $urandom_range(0, DIM_W - 1);
                    1: r.tex_height   ^= 16'd1 << $urandom_range(0, DIM_W - 1);
                    2: r.pixel_format ^= 8'd1 << $urandom_range(0, CODE_W - 1);
                    default: r.usage_bits ^= 8'd1 << $urandom_range(0, CODE_W - 1);
                endcase
            end
            else if ($urandom_range(0, 7) == 0)
            begin
                r.host_visible = ~r.host_visible;
            end
            else
            begin
                r.buffer_bytes ^= 32'd1 << $urandom_range(0, BYTES_W - 1);
            end
        end
        else
        begin
            r = key_slots[idx];
        end
        if (r.kind == KIND_TEXTURE)
        begin
            r = tex_item(CMD_ACQUIRE, r.tex_width, r.tex_height, r.pixel_format, r.usage_bits,
                         '0);
        end
        else
        begin
            r = buf_item(CMD_ACQUIRE, r.buffer_bytes, r.host_visible, '0);
        end
        cmd_roll = $urandom_range(0, 99);
        if (cmd_roll < 1)
        begin
            r.cmd = CMD_CLEAR;
        end
        else if (cmd_roll < 3)
        begin
            r.cmd = CMD_NOP;
        end
        else if (cmd_roll < 3 + release_pct)
        begin
            r.cmd = CMD_RELEASE;
        end
        // Acquires carry handle bits too; the block must ignore them.
        r.handle_in = ($urandom_range(0, 19) == 0) ? '0 : HANDLE_W'($urandom_range(1, 65535));
        return r;
    endfunction

    // ------------------------------------------------------------------------------------
    // Channel tasks.
    // ------------------------------------------------------------------------------------

    // Offers one request beat after an idle gap and holds it until the block takes it.
    // Valid is left high afterwards so that back-to-back beats never lower and raise it in
    // the same time step; whoever stops sending calls wait_drained, which lowers it.
    task automatic send_request(input pool_req_t r, input int gap);
        if (gap > 0)
        begin
            @(negedge clk);
            req_if.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        req_if.valid        <= 1'b1;
        req_if.cmd          <= r.cmd;
        req_if.kind         <= r.kind;
        req_if.tex_width    <= r.tex_width;
        req_if.tex_height   <= r.tex_height;
        req_if.pixel_format <= r.pixel_format;
        req_if.usage_bits   <= r.usage_bits;
        req_if.buffer_bytes <= r.buffer_bytes;
        req_if.host_visible <= r.host_visible;
        req_if.handle_in    <= r.handle_in;
        @(posedge clk);
        while (!req_if.ready)
        begin
            @(posedge clk);
        end
        expected_results.insert(expected_results.size(), predict_pool_step(r));
        items_sent++;
    endtask

    // Stops offering requests and waits until every predicted result has been taken.
    task automatic wait_drained();
        @(negedge clk);
        req_if.valid <= 1'b0;
        while (expected_results.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Writes one limit register. Every request causes a result, so an empty queue of
    // expectations means the block is idle.
    task automatic write_limit(input logic [CFG_INDEX_W-1:0] idx, input int value);
        wait_drained();
        @(negedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= CFG_DATA_W'(value);
        @(posedge clk);
        while (!cfg_if.ready)
        begin
            @(posedge clk);
        end
        if (idx == REG_MAX_TEXTURES)
        begin
            tex_limit = value;
        end
        else
        begin
            buf_limit = value;
        end
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic set_limits(input int textures, input int buffers);
        write_limit(REG_MAX_TEXTURES, textures);
        write_limit(REG_MAX_BUFFERS, buffers);
    endtask

    // ------------------------------------------------------------------------------------
    // Result side: the receiver's ready, and the checker.
    // ------------------------------------------------------------------------------------

    // Ready is driven at the falling edge. A hold requested by a test is counted down here,
    // one cycle at a time; otherwise the receiver stalls at random unless traffic is steady.
    initial
    begin : result_ready_driver
        int stall_left;
        stall_left   = 0;
        rsp_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (result_hold_cycles > 0)
            begin
                rsp_if.ready <= 1'b0;
                result_hold_cycles--;
            end
            else if (steady_flow)
            begin
                rsp_if.ready <= 1'b1;
            end
            else
            begin
                if (stall_left == 0 && $urandom_range(0, 3) == 0)
                begin
                    stall_left = pick_gap();
                end
                rsp_if.ready <= (stall_left == 0);
                if (stall_left > 0)
                begin
                    stall_left--;
                end
            end
        end
    end

    task automatic check_field(input string name, input logic [STAT_W-1:0] want,
                               input logic [STAT_W-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            errors++;
        end
    endtask

    // Every result beat is matched against the oldest expectation, field by field.
    always @(posedge clk)
    begin
        krp_rsp_t want;
        if (rst_n && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
        begin
            results_seen++;
            if (expected_results.size() == 0)
            begin
                $error("result beat with no request outstanding");
                errors++;
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("hit", STAT_W'(want.hit), STAT_W'(rsp_if.hit));
                check_field("handle_out", STAT_W'(want.handle_out),
                            STAT_W'(rsp_if.handle_out));
                check_field("dropped", STAT_W'(want.dropped), STAT_W'(rsp_if.dropped));
                check_field("pooled_textures", STAT_W'(want.pooled_textures),
                            STAT_W'(rsp_if.pooled_textures));
                check_field("pooled_buffers", STAT_W'(want.pooled_buffers),
                            STAT_W'(rsp_if.pooled_buffers));
                check_field("hit_count", want.hit_count, rsp_if.hit_count);
                check_field("miss_count", want.miss_count, rsp_if.miss_count);
            end
        end
    end

    // ------------------------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------------------------

    // Both limits are zero out of reset: every real release drops, a null release does not,
    // and an acquire on the empty pool misses.
    task automatic test_reset_defaults();
        send_request(tex_item(CMD_RELEASE, 16'd7, 16'd9, 8'd1, 8'd2, 16'h0005), next_gap());
        send_request(buf_item(CMD_RELEASE, 32'd4096, 1'b1, 16'h0010), next_gap());
        send_request(tex_item(CMD_ACQUIRE, 16'd7, 16'd9, 8'd1, 8'd2, 16'h0000), next_gap());
        send_request(buf_item(CMD_RELEASE, 32'd4096, 1'b0, 16'h0000), next_gap());
        send_request(buf_item(CMD_NOP, 32'd1, 1'b0, 16'h0001), next_gap());
        send_request(tex_item(CMD_CLEAR, 16'd0, 16'd0, 8'd0, 8'd0, 16'h0000), next_gap());
        wait_drained();
    endtask

    // Field extremes, per-key LIFO order, removal from the middle of the stack, kind and
    // host-visibility mismatches, limit drops, null release, the no-op code and clear.
    task automatic test_directed_ops();
        set_limits(3, 2);
        send_request(tex_item(CMD_RELEASE, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 16'hFFFF), next_gap());
        send_request(tex_item(CMD_RELEASE, 16'h0000, 16'h0000, 8'h00, 8'h00, 16'h0001), next_gap());
        send_request(buf_item(CMD_RELEASE, 32'hFFFF_FFFF, 1'b1, 16'h1234), next_gap());
        send_request(tex_item(CMD_RELEASE, 16'h0000, 16'h0000, 8'h00, 8'h00, 16'h8000), next_gap());
        // Texture limit of three is reached here.
        send_request(tex_item(CMD_RELEASE, 16'h0001, 16'h0000, 8'h00, 8'h00, 16'h0042), next_gap());
        send_request(buf_item(CMD_RELEASE, 32'h0000_0000, 1'b0, 16'hABCD), next_gap());
        send_request(buf_item(CMD_ACQUIRE, 32'h0000_0000, 1'b1, 16'h0000), next_gap());
        send_request(tex_item(CMD_ACQUIRE, 16'h0000, 16'h0000, 8'h00, 8'h00, 16'h0000), next_gap());
        send_request(tex_item(CMD_ACQUIRE, 16'h0000, 16'h0000, 8'h00, 8'h00, 16'h0000), next_gap());
        send_request(tex_item(CMD_ACQUIRE, 16'h0000, 16'h0000, 8'h00, 8'h00, 16'h0000), next_gap());
        send_request(buf_item(CMD_ACQUIRE, 32'hFFFF_FFFF, 1'b1, 16'hFFFF), next_gap());
        send_request(tex_item(CMD_ACQUIRE, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFE, 16'h0000), next_gap());
        send_request(buf_item(CMD_RELEASE, 32'h0000_0000, 1'b0, 16'h0000), next_gap());
        send_request(buf_item(CMD_NOP, 32'hFFFF_FFFF, 1'b1, 16'hFFFF), next_gap());
        send_request(buf_item(CMD_CLEAR, 32'h0000_0000, 1'b0, 16'h0000), next_gap());
        send_request(tex_item(CMD_ACQUIRE, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 16'h0000), next_gap());
        send_request(buf_item(CMD_RELEASE, 32'h0000_0000, 1'b0, 16'hFFFF), next_gap());
        send_request(buf_item(CMD_RELEASE, 32'h0000_0000, 1'b0, 16'h0002), next_gap());
        // Buffer limit of two is reached here.
        send_request(buf_item(CMD_RELEASE, 32'h0000_0000, 1'b0, 16'h0003), next_gap());
        // Same low key bits, other kind: must miss.
        send_request(tex_item(CMD_ACQUIRE, 16'h0000, 16'h0000, 8'h00, 8'h00, 16'h0000), next_gap());
        send_request(buf_item(CMD_ACQUIRE, 32'h0000_0000, 1'b0, 16'h0000), next_gap());
        send_request(tex_item(CMD_CLEAR, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 16'hFFFF), next_gap());
        wait_drained();
    endtask

    // Fills the shared table with both limits at the table depth, so that only the table size
    // stops further releases, then takes entries from the bottom and the middle.
    task automatic test_table_full();
        set_limits(64, 64);
        for (int i = 0; i < 40; i++)
        begin
            send_request(tex_item(CMD_RELEASE, 16'(i), 16'd3, 8'd5, 8'd1, 16'(i + 100)),
                         next_gap());
        end
        for (int i = 0; i < 24; i++)
        begin
            send_request(buf_item(CMD_RELEASE, 32'(i * 256), 1'b1, 16'(i + 500)), next_gap());
        end
        send_request(tex_item(CMD_RELEASE, 16'd999, 16'd3, 8'd5, 8'd1, 16'h7777), next_gap());
        send_request(buf_item(CMD_RELEASE, 32'd1, 1'b0, 16'h6666), next_gap());
        send_request(tex_item(CMD_ACQUIRE, 16'd0, 16'd3, 8'd5, 8'd1, 16'h0000), next_gap());
        send_request(buf_item(CMD_ACQUIRE, 32'd2560, 1'b1, 16'h0000), next_gap());
        send_request(buf_item(CMD_RELEASE, 32'd1, 1'b0, 16'h6666), next_gap());
        send_request(buf_item(CMD_ACQUIRE, 32'd1, 1'b0, 16'h0000), next_gap());
        send_request(tex_item(CMD_CLEAR, 16'd0, 16'd0, 8'd0, 8'd0, 16'h0000), next_gap());
        wait_drained();
    endtask

    // The receiver holds ready low for a long stretch while the sender keeps offering beats
    // back to back, so the block stalls its input; then the sender waits for a full drain.
    task automatic test_result_backpressure();
        set_limits(8, 8);
        for (int i = 0; i < 8; i++)
        begin
            refresh_key_slot(i);
        end
        result_hold_cycles = 300;
        for (int i = 0; i < 12; i++)
        begin
            send_request(random_item(60), 0);
        end
        wait_drained();
        for (int i = 0; i < 12; i++)
        begin
            send_request(random_item(40), 0);
        end
        wait_drained();
    endtask

    task automatic run_random_phase(input int textures, input int buffers,
                                    input int release_pct, input bit steady, input int count);
        set_limits(textures, buffers);
        steady_flow = steady;
        for (int i = 0; i < count; i++)
        begin
            send_request(random_item(release_pct), next_gap());
        end
        wait_drained();
        steady_flow = 1'b0;
    endtask

    // Random traffic over several limit settings, the extremes among them, ending with a
    // release-heavy phase that fills the table and a phase with no idling on either side.
    task automatic test_random_traffic();
        for (int i = 0; i < 8; i++)
        begin
            refresh_key_slot(i);
        end
        run_random_phase(64, 64, 48, 1'b0, 85);
        run_random_phase(0, 64, 48, 1'b0, 85);
        run_random_phase(64, 0, 48, 1'b0, 85);
        run_random_phase(1, 1, 48, 1'b0, 85);
        run_random_phase(3, 7, 48, 1'b0, 85);
        run_random_phase($urandom_range(0, 64), $urandom_range(0, 64), 48, 1'b0, 85);
        run_random_phase(64, 64, 75, 1'b0, 85);
        run_random_phase(64, 64, 55, 1'b1, 85);
    endtask

    // ------------------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------------------
    initial
    begin : main_sequence
        // Every input of the block is known from time zero.
        rst_n               = 1'b0;
        req_if.valid        = 1'b0;
        req_if.cmd          = CMD_ACQUIRE;
        req_if.kind         = KIND_TEXTURE;
        req_if.tex_width    = '0;
        req_if.tex_height   = '0;
        req_if.pixel_format = '0;
        req_if.usage_bits   = '0;
        req_if.buffer_bytes = '0;
        req_if.host_visible = 1'b0;
        req_if.handle_in    = '0;
        cfg_if.valid        = 1'b0;
        cfg_if.index        = REG_MAX_TEXTURES;
        cfg_if.data         = '0;
        steady_flow         = 1'b0;
        result_hold_cycles  = 0;
        errors              = 0;
        items_sent          = 0;
        results_seen        = 0;
        drops_predicted     = 0;
        full_table_events   = 0;
        pooled_tex          = 0;
        pooled_buf          = 0;
        hit_total           = '0;
        miss_total          = '0;
        tex_limit           = 0;
        buf_limit           = 0;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_directed_ops();
        test_table_full();
        test_result_backpressure();
        test_random_traffic();

        wait_drained();
        // Leave room for a stray beat the block might still produce.
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_results.size() != 0)
        begin
            $error("%0d expected results never arrived", expected_results.size());
            errors++;
        end

        $display("run covered %0d requests and %0d result beats: %0d hits, %0d misses,",
                 items_sent, results_seen, hit_total, miss_total);
        $display("%0d dropped releases and %0d times the table filled completely",
                 drops_predicted, full_table_events);
        if (errors == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
